// ===== rtl/sliding_window_convolution_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window convolution
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_CONVOLUTION_MACROS_SVH
`define SLIDING_WINDOW_CONVOLUTION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define SWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swc assertion failed");

`else

`define SWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg
// Shared constants, types and codes of the sliding window convolution.
// ----------------------------------------------------------------------------
package swc_pkg;

  // Filter geometry and buffer sizes
  localparam int KERNEL     = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int LINES      = KERNEL - 1;
  localparam int RESET_SIZE = 64;

  // Datapath widths
  localparam int PIX_W      = 16;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int CSUM_W     = PROD_W + $clog2(KERNEL);
  localparam int SUM_W      = 40;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int COEF_IDX_W = 4;

  // Item operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_COEF  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CSUM_W-1:0] csum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [COL_W-1:0]         col_cnt_t;
  typedef logic [ROW_W-1:0]         row_cnt_t;

  // Per-cell control: pipeline advance, window shift, coefficient writes
  typedef struct packed {
    logic              advance;
    logic              shift;
    logic [KERNEL-1:0] coef_we;
  } cell_ctrl_t;

endpackage

// ===== rtl/sliding_window_convolution.sv =====
// ----------------------------------------------------------------------------
// sliding_window_convolution: streaming KxK convolution with line buffers
// A pixel's result passes stages 1 to 4 and the output register before out_valid shows it.
// Throughput: one item per cycle; in_stall rises only while both output
// register and skid register are full, set by the output skid stage.
// Reset: counters, window and coefficients clear, both sizes return to 64;
// the line buffer RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sliding_window_convolution_macros.svh"

module sliding_window_convolution (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic signed [swc_pkg::PIX_W-1:0]     in_pixel,
  input  logic                                 in_frame_start,
  input  logic [swc_pkg::COEF_IDX_W-1:0]       in_coef_index,
  input  logic signed [swc_pkg::PIX_W-1:0]     in_coef_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swc_pkg::SUM_W-1:0]     out_window_sum,
  output logic                                 out_last,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swc_pkg::CFG_W-1:0]            cfg_data
);

  // --------------------------------------------------------------------------
  // Size registers, stored as clamped "last index" values
  // --------------------------------------------------------------------------
  function automatic swc_pkg::col_cnt_t line_last_of(input logic [swc_pkg::CFG_W-1:0] v);
    swc_pkg::col_cnt_t res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > swc_pkg::MAX_WIDTH) begin
      res = swc_pkg::col_cnt_t'(swc_pkg::MAX_WIDTH - 1);
    end else begin
      res = swc_pkg::col_cnt_t'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic swc_pkg::row_cnt_t frame_last_of(input logic [swc_pkg::CFG_W-1:0] v);
    swc_pkg::row_cnt_t res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > swc_pkg::MAX_ROWS) begin
      res = swc_pkg::row_cnt_t'(swc_pkg::MAX_ROWS - 1);
    end else begin
      res = swc_pkg::row_cnt_t'(v - 1'b1);
    end
    return res;
  endfunction

  swc_pkg::col_cnt_t line_last_r;
  swc_pkg::row_cnt_t frame_last_r;

  // Writes must land only while idle; the block does not enforce this and takes every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_last_r  <= line_last_of(swc_pkg::CFG_W'(swc_pkg::RESET_SIZE));
      frame_last_r <= frame_last_of(swc_pkg::CFG_W'(swc_pkg::RESET_SIZE));
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swc_pkg::REG_LINE_WIDTH: line_last_r  <= line_last_of(cfg_data);
        swc_pkg::REG_FRAME_ROWS: frame_last_r <= frame_last_of(cfg_data);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid register holds
  // a result. Because in_stall comes straight from a flop, out_stall never
  // reaches the input side in the same cycle.
  // --------------------------------------------------------------------------
  logic skid_valid_r;
  logic advance;
  logic in_xfer;
  logic pix_xfer;
  logic cld_xfer;

  assign advance  = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign pix_xfer = in_xfer && (in_op == swc_pkg::OP_PIXEL);
  assign cld_xfer = in_xfer && (in_op == swc_pkg::OP_COEF);

  // --------------------------------------------------------------------------
  // Stage 0: raster counters and line buffer read
  // --------------------------------------------------------------------------
  swc_pkg::col_cnt_t col_cnt_r, col_cnt_nxt, cur_col, rd_addr;
  swc_pkg::row_cnt_t row_cnt_r, row_cnt_nxt, cur_row;
  logic              produce;
  logic              is_last;

  always_comb begin
    // frame_start clears the counters before this pixel is placed
    cur_col = in_frame_start ? '0 : col_cnt_r;
    cur_row = in_frame_start ? '0 : row_cnt_r;
    // hold the address inside the row when the width shrank under the counter
    rd_addr = (cur_col > line_last_r) ? line_last_r : cur_col;
    produce = (cur_col >= swc_pkg::col_cnt_t'(swc_pkg::KERNEL - 1)) &&
              (cur_row >= swc_pkg::row_cnt_t'(swc_pkg::KERNEL - 1));
    is_last = (cur_col == line_last_r) && (cur_row == frame_last_r);

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (pix_xfer) begin
      if (cur_col >= line_last_r) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (cur_row >= frame_last_r) ? '0 : cur_row + 1'b1;
      end else begin
        col_cnt_nxt = cur_col + 1'b1;
        row_cnt_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: build the new window column, rotate it up through the line
  // buffers and shift it into the cell chain.
  // --------------------------------------------------------------------------
  logic                              s1_pix_r;
  logic                              s1_cld_r;
  logic                              s1_res_r;
  logic                              s1_last_r;
  logic                              s1_byp_r;
  swc_pkg::pix_t                     s1_pixel_r;
  swc_pkg::col_cnt_t                 s1_addr_r;
  logic [swc_pkg::COEF_IDX_W-1:0]    s1_idx_r;
  swc_pkg::pix_t                     s1_cval_r;
  swc_pkg::pix_t                     s1_byp_data_r [swc_pkg::LINES];
  swc_pkg::pix_t                     s1_col [swc_pkg::KERNEL];
  logic [swc_pkg::PIX_W-1:0]         ram_rd_data [swc_pkg::LINES];
  logic                              ram_we;
  logic                              byp_hit;

  // Row slot r feeds window row r; the newest pixel is the bottom row. A
  // write from stage 1 to the address just being read is forwarded, since
  // the RAM read would still return the old word.
  always_comb begin
    for (int r = 0; r < swc_pkg::LINES; r++) begin
      s1_col[r] = s1_byp_r ? s1_byp_data_r[r] : $signed(ram_rd_data[r]);
    end
    s1_col[swc_pkg::KERNEL-1] = s1_pixel_r;
  end

  assign ram_we  = advance && s1_pix_r;
  assign byp_hit = ram_we && (s1_addr_r == rd_addr);

  for (genvar r = 0; r < swc_pkg::LINES; r++) begin : g_line
    swc_ram #(
      .WIDTH (swc_pkg::PIX_W),
      .DEPTH (swc_pkg::MAX_WIDTH)
    ) u_line_ram (
      .clk     (clk),
      .we      (ram_we),
      .waddr   (s1_addr_r),
      .wdata   (s1_col[r+1]),
      .re      (pix_xfer),
      .raddr   (rd_addr),
      .rd_data (ram_rd_data[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r  <= 1'b0;
      s1_cld_r  <= 1'b0;
      s1_res_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s1_byp_r  <= 1'b0;
    end else if (advance) begin
      s1_pix_r  <= pix_xfer;
      s1_cld_r  <= cld_xfer;
      s1_res_r  <= pix_xfer && produce;
      s1_last_r <= pix_xfer && produce && is_last;
      s1_byp_r  <= pix_xfer && byp_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pixel_r <= in_pixel;
      s1_addr_r  <= rd_addr;
      s1_idx_r   <= in_coef_index;
      s1_cval_r  <= in_coef_value;
      for (int r = 0; r < swc_pkg::LINES; r++) begin
        s1_byp_data_r[r] <= s1_col[r+1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cells multiply the window they hold. A coefficient load applies
  // here, so it lines up with the pixels around it in stream order.
  // Stage 3: products registered; stage 4: column sums registered.
  // --------------------------------------------------------------------------
  logic                              s2_cld_r;
  logic                              s2_res_r;
  logic                              s2_last_r;
  logic [swc_pkg::COEF_IDX_W-1:0]    s2_idx_r;
  swc_pkg::pix_t                     s2_cval_r;
  logic                              s3_res_r;
  logic                              s3_last_r;
  logic                              s4_res_r;
  logic                              s4_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_cld_r  <= 1'b0;
      s2_res_r  <= 1'b0;
      s2_last_r <= 1'b0;
      s3_res_r  <= 1'b0;
      s3_last_r <= 1'b0;
      s4_res_r  <= 1'b0;
      s4_last_r <= 1'b0;
    end else if (advance) begin
      s2_cld_r  <= s1_cld_r;
      s2_res_r  <= s1_res_r;
      s2_last_r <= s1_last_r;
      s3_res_r  <= s2_res_r;
      s3_last_r <= s2_last_r;
      s4_res_r  <= s3_res_r;
      s4_last_r <= s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_idx_r  <= s1_idx_r;
      s2_cval_r <= s1_cval_r;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 takes the new column, cell c hands its column to
  // cell c+1. Cell c holds the window column that coefficient column
  // KERNEL-1-c weights, so it owns those coefficients.
  // --------------------------------------------------------------------------
  swc_pkg::cell_ctrl_t cell_ctrl [swc_pkg::KERNEL];
  swc_pkg::pix_t       win_col   [swc_pkg::KERNEL][swc_pkg::KERNEL];
  swc_pkg::csum_t      cell_sum  [swc_pkg::KERNEL];

  always_comb begin
    for (int c = 0; c < swc_pkg::KERNEL; c++) begin
      cell_ctrl[c].advance = advance;
      cell_ctrl[c].shift   = advance && s1_pix_r;
      for (int r = 0; r < swc_pkg::KERNEL; r++) begin
        // out-of-range indexes match no cell and drop
        cell_ctrl[c].coef_we[r] = advance && s2_cld_r &&
          (int'(s2_idx_r) == (swc_pkg::KERNEL - 1 - c) * swc_pkg::KERNEL + r);
      end
    end
  end

  for (genvar c = 0; c < swc_pkg::KERNEL; c++) begin : g_cell
    if (c == 0) begin : g_head
      swc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl[c]),
        .col_in     (s1_col),
        .coef_value (s2_cval_r),
        .col_out    (win_col[c]),
        .col_sum    (cell_sum[c])
      );
    end else begin : g_body
      swc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl[c]),
        .col_in     (win_col[c-1]),
        .coef_value (s2_cval_r),
        .col_out    (win_col[c]),
        .col_sum    (cell_sum[c])
      );
    end
  end

  // Total over the column sums; exact in 40 bits for KERNEL = 3.
  swc_pkg::sum_t res_sum;

  always_comb begin
    res_sum = '0;
    for (int c = 0; c < swc_pkg::KERNEL; c++) begin
      res_sum = res_sum + swc_pkg::sum_t'(cell_sum[c]);
    end
  end

  // --------------------------------------------------------------------------
  // Output register plus skid register. A result from stage 4 goes to the
  // output register when it is free or being drained, otherwise it parks
  // in the skid register and the pipeline holds.
  // --------------------------------------------------------------------------
  logic          out_valid_r;
  swc_pkg::sum_t out_sum_r;
  logic          out_last_r;
  swc_pkg::sum_t skid_sum_r;
  logic          skid_last_r;
  logic          res_push;
  logic          out_xfer;

  assign res_push = advance && s4_res_r;
  assign out_xfer = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (out_valid_r && !out_xfer) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_sum_r  <= skid_sum_r;
        out_last_r <= skid_last_r;
      end
    end else if (res_push) begin
      if (!out_valid_r || out_xfer) begin
        out_sum_r  <= res_sum;
        out_last_r <= s4_last_r;
      end else begin
        skid_sum_r  <= res_sum;
        skid_last_r <= s4_last_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_sum = out_sum_r;
  assign out_last       = out_last_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SWC_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SWC_ASSERT_NEXT(a_frozen_when_full, clk, rst_n, skid_valid_r, $stable(s4_res_r))
  `SWC_ASSERT_NOW(a_last_has_result, clk, rst_n, s4_last_r, s4_res_r)
  `SWC_ASSERT_NOW(a_bypass_on_pixel, clk, rst_n, s1_byp_r, s1_pix_r)

endmodule

// ===== rtl/swc_ram.sv =====
// ----------------------------------------------------------------------------
// swc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/swc_cell.sv =====
// ----------------------------------------------------------------------------
// swc_cell
// One window column: holds KERNEL pixels and their coefficients, hands the
// column to its neighbor on every shift and forms a registered column sum.
// ----------------------------------------------------------------------------
module swc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swc_pkg::cell_ctrl_t ctrl,
  input  swc_pkg::pix_t       col_in [swc_pkg::KERNEL],
  input  swc_pkg::pix_t       coef_value,
  output swc_pkg::pix_t       col_out [swc_pkg::KERNEL],
  output swc_pkg::csum_t      col_sum
);

  swc_pkg::pix_t  win_r    [swc_pkg::KERNEL];
  swc_pkg::pix_t  coef_r   [swc_pkg::KERNEL];
  swc_pkg::prod_t prod_r   [swc_pkg::KERNEL];
  swc_pkg::prod_t prod_nxt [swc_pkg::KERNEL];
  swc_pkg::csum_t col_sum_r;
  swc_pkg::csum_t col_sum_nxt;

  always_comb begin
    col_sum_nxt = '0;
    for (int r = 0; r < swc_pkg::KERNEL; r++) begin
      prod_nxt[r] = win_r[r] * coef_r[r];
      col_sum_nxt = col_sum_nxt + swc_pkg::csum_t'(prod_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '{default: '0};
      coef_r <= '{default: '0};
    end else begin
      if (ctrl.shift) begin
        win_r <= col_in;
      end
      for (int r = 0; r < swc_pkg::KERNEL; r++) begin
        if (ctrl.coef_we[r]) begin
          coef_r[r] <= coef_value;
        end
      end
    end
  end

  // Products and column sum follow the pipeline; hold while stalled.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod_r    <= prod_nxt;
      col_sum_r <= col_sum_nxt;
    end
  end

  assign col_out = win_r;
  assign col_sum = col_sum_r;

endmodule
